// ===== hw/rtl/llc_pkg.sv =====
package llc_pkg;

  localparam int unsigned POOL_NODES_DEF = 256;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CMD_W          = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 4'd0,
    CMD_INS_HEAD  = 4'd1,
    CMD_CUR_HEAD  = 4'd2,
    CMD_DEL_HEAD  = 4'd3,
    CMD_DEL_NEXT  = 4'd4,
    CMD_INS_NEXT  = 4'd5,
    CMD_OVERWRITE = 4'd6,
    CMD_ADVANCE   = 4'd7,
    CMD_QUERY     = 4'd8
  } llc_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_LINK,
    S_DONE
  } llc_state_e;

  // controller to datapath: one strobe for each phase of a command
  typedef struct packed {
    logic accept;
    logic read2;
    logic exec;
    logic link_wr;
  } llc_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
  } llc_item_t;

  typedef struct packed {
    logic                     pool_full;
    logic                     head_valid;
    logic signed [DATA_W-1:0] head_value;
    logic                     cursor_valid;
    logic signed [DATA_W-1:0] cursor_value;
  } llc_result_t;

endpackage

// ===== hw/rtl/llc_ram.sv =====
module llc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/llc_ctrl.sv =====
module llc_ctrl
  import llc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output llc_ctrl_t ctrl_o,
  output logic      busy_o,
  output logic      done_o
);

  llc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_EXEC;
      S_EXEC:  state_d = S_LINK;
      S_LINK:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o        = 1'b0;
        ctrl_o.accept = start_i;
      end
      S_READ:  ctrl_o.read2   = 1'b1;
      S_EXEC:  ctrl_o.exec    = 1'b1;
      S_LINK:  ctrl_o.link_wr = 1'b1;
      S_DONE:  done_o         = 1'b1;
      default: busy_o         = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/llc_datapath.sv =====
module llc_datapath
  import llc_pkg::*;
#(
  parameter int unsigned POOL_NODES = POOL_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  llc_ctrl_t   ctrl_i,
  input  llc_item_t   item_i,
  output llc_result_t result_o
);

  localparam int unsigned IW = $clog2(POOL_NODES);
  localparam int unsigned PW = $clog2(POOL_NODES + 1);
  localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

  function automatic logic is_node(logic [PW-1:0] p);
    return p < NIL;
  endfunction

  function automatic logic [IW-1:0] to_idx(logic [PW-1:0] p);
    return is_node(p) ? p[IW-1:0] : '0;
  endfunction

  // list pointers (control state)
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] free_q, free_d;
  logic [PW-1:0] fresh_q, fresh_d;

  // payload
  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [PW-1:0]            t1_q, t1_d;
  logic [PW-1:0]            n_q, n_d;
  logic signed [DATA_W-1:0] head_val_q, head_val_d;
  logic signed [DATA_W-1:0] cur_val_q, cur_val_d;
  logic                     full_q, full_d;

  // memory ports
  logic              l_we, l_re, v_we, v_re;
  logic [IW-1:0]     l_waddr, l_raddr, v_waddr, v_raddr;
  logic [PW-1:0]     l_wdata, l_rdata;
  logic [DATA_W-1:0] v_wdata, v_rdata;

  logic          head_ok, cur_ok, free_ok, fresh_ok, alloc_ok, next_ok;
  logic [PW-1:0] alloc_n;

  assign head_ok  = is_node(head_q);
  assign cur_ok   = is_node(cur_q);
  assign free_ok  = is_node(free_q);
  assign fresh_ok = fresh_q < NIL;
  assign alloc_ok = free_ok | fresh_ok;
  assign alloc_n  = free_ok ? free_q : fresh_q;
  assign next_ok  = is_node(t1_q);

  llc_ram #(
    .WIDTH(PW),
    .DEPTH(POOL_NODES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(l_wdata),
    .re_i   (l_re),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  llc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(POOL_NODES)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(v_waddr),
    .wdata_i(v_wdata),
    .re_i   (v_re),
    .raddr_i(v_raddr),
    .rdata_o(v_rdata)
  );

  // reads: first link on transfer, second link or value in the cycle after
  always_comb begin
    l_re    = 1'b0;
    l_raddr = to_idx(cur_q);
    v_re    = 1'b0;
    v_raddr = to_idx(l_rdata);
    if (ctrl_i.accept) begin
      l_re = 1'b1;
      case (item_i.cmd)
        CMD_INS_HEAD: l_raddr = to_idx(free_q);
        CMD_DEL_HEAD: l_raddr = to_idx(head_q);
        default:      l_raddr = to_idx(cur_q);
      endcase
    end
    if (ctrl_i.read2) begin
      case (cmd_q)
        CMD_DEL_NEXT: begin
          l_re    = 1'b1;
          l_raddr = to_idx(l_rdata);
        end
        CMD_INS_NEXT: begin
          l_re    = 1'b1;
          l_raddr = to_idx(free_q);
        end
        CMD_DEL_HEAD, CMD_ADVANCE: v_re = 1'b1;
        default: ;
      endcase
    end
  end

  // writes: at most one per memory in each of the exec and link cycles
  always_comb begin
    l_we    = 1'b0;
    l_waddr = to_idx(cur_q);
    l_wdata = free_q;
    v_we    = 1'b0;
    v_waddr = to_idx(cur_q);
    v_wdata = val_q;
    if (ctrl_i.exec) begin
      case (cmd_q)
        CMD_INS_HEAD: begin
          if (alloc_ok) begin
            v_we    = 1'b1;
            v_waddr = to_idx(alloc_n);
            l_we    = 1'b1;
            l_waddr = to_idx(alloc_n);
            l_wdata = head_q;
          end
        end
        CMD_DEL_HEAD: begin
          if (head_ok) begin
            l_we    = 1'b1;
            l_waddr = to_idx(head_q);
            l_wdata = free_q;
          end
        end
        CMD_DEL_NEXT: begin
          // unlink: cursor skips the victim
          if (cur_ok && next_ok) begin
            l_we    = 1'b1;
            l_waddr = to_idx(cur_q);
            l_wdata = l_rdata;
          end
        end
        CMD_INS_NEXT: begin
          if (cur_ok && alloc_ok) begin
            v_we    = 1'b1;
            v_waddr = to_idx(alloc_n);
            l_we    = 1'b1;
            l_waddr = to_idx(alloc_n);
            l_wdata = t1_q;
          end
        end
        CMD_OVERWRITE: begin
          v_we = cur_ok;
        end
        default: ;
      endcase
    end
    if (ctrl_i.link_wr) begin
      case (cmd_q)
        CMD_DEL_NEXT: begin
          // push the victim onto the free list
          if (cur_ok && next_ok) begin
            l_we    = 1'b1;
            l_waddr = to_idx(t1_q);
            l_wdata = free_q;
          end
        end
        CMD_INS_NEXT: begin
          if (cur_ok && is_node(n_q)) begin
            l_we    = 1'b1;
            l_waddr = to_idx(cur_q);
            l_wdata = n_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    head_d     = head_q;
    cur_d      = cur_q;
    free_d     = free_q;
    fresh_d    = fresh_q;
    cmd_d      = cmd_q;
    val_d      = val_q;
    t1_d       = t1_q;
    n_d        = n_q;
    head_val_d = head_val_q;
    cur_val_d  = cur_val_q;
    full_d     = full_q;
    if (ctrl_i.accept) begin
      cmd_d  = item_i.cmd;
      val_d  = item_i.value;
      full_d = 1'b0;
    end
    if (ctrl_i.read2) begin
      t1_d = l_rdata;
    end
    if (ctrl_i.exec) begin
      n_d = alloc_ok ? alloc_n : NIL;
      case (cmd_q)
        CMD_CLEAR: begin
          head_d  = NIL;
          cur_d   = NIL;
          free_d  = NIL;
          fresh_d = '0;
        end
        CMD_INS_HEAD: begin
          if (alloc_ok) begin
            head_d     = alloc_n;
            head_val_d = val_q;
            if (free_ok) begin
              free_d = t1_q;
            end else begin
              fresh_d = fresh_q + PW'(1);
            end
          end else begin
            full_d = 1'b1;
          end
        end
        CMD_CUR_HEAD: begin
          cur_d     = head_q;
          cur_val_d = head_val_q;
        end
        CMD_DEL_HEAD: begin
          if (head_ok) begin
            if (cur_q == head_q) begin
              cur_d = NIL;
            end
            head_d     = next_ok ? t1_q : NIL;
            head_val_d = v_rdata;
            free_d     = head_q;
          end
        end
        CMD_INS_NEXT: begin
          if (cur_ok) begin
            if (alloc_ok) begin
              if (free_ok) begin
                free_d = l_rdata;
              end else begin
                fresh_d = fresh_q + PW'(1);
              end
            end else begin
              full_d = 1'b1;
            end
          end
        end
        CMD_OVERWRITE: begin
          if (cur_ok) begin
            cur_val_d = val_q;
            if (head_q == cur_q) begin
              head_val_d = val_q;
            end
          end
        end
        CMD_ADVANCE: begin
          if (cur_ok) begin
            cur_d     = next_ok ? t1_q : NIL;
            cur_val_d = v_rdata;
          end
        end
        default: ;
      endcase
    end
    if (ctrl_i.link_wr && cmd_q == CMD_DEL_NEXT && cur_ok && next_ok) begin
      free_d = t1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NIL;
      cur_q   <= NIL;
      free_q  <= NIL;
      fresh_q <= '0;
    end else begin
      head_q  <= head_d;
      cur_q   <= cur_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    t1_q       <= t1_d;
    n_q        <= n_d;
    head_val_q <= head_val_d;
    cur_val_q  <= cur_val_d;
    full_q     <= full_d;
  end

  always_comb begin
    result_o.pool_full    = full_q;
    result_o.head_valid   = head_ok;
    result_o.head_value   = head_ok ? head_val_q : '0;
    result_o.cursor_valid = cur_ok;
    result_o.cursor_value = cur_ok ? cur_val_q : '0;
  end

endmodule

// ===== hw/rtl/linked_list_with_cursor_core.sv =====
// Channel  | Ports                    | Transfer
// ---------+--------------------------+-------------------------------
// command  | start, item_i, busy      | start high while busy is low
// result   | done_o, result_o         | done_o high, one cycle only
//
// The result strobe follows the transfer through the read, exec and link
// states, and busy is low again in the cycle after the strobe, so a new
// command is not taken before the last one is through. The sequence is
// set by the link memory: delete after cursor makes two dependent
// synchronous reads and then two writes through its single write port.
// Reset clears the pointers and the fresh-node counter at once; the node
// memories need no clearing. The receiver cannot stall the result.
module linked_list_with_cursor_core
  import llc_pkg::*;
#(
  parameter int unsigned POOL_NODES = POOL_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  llc_item_t   item_i,
  output logic        busy,
  output llc_result_t result_o,
  output logic        done_o
);

  llc_ctrl_t ctrl;

  llc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .ctrl_o (ctrl),
    .busy_o (busy),
    .done_o (done_o)
  );

  llc_datapath #(
    .POOL_NODES(POOL_NODES)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .item_i  (item_i),
    .result_o(result_o)
  );

endmodule
